// ===== src/mdab_pkg.sv =====
// shared types and codes for the min-days shortest-path budget search
// no dependencies
package mdab_pkg;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PREP   = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_INIT   = 9'b000001000,
    S_FWROW  = 9'b000010000,
    S_FWCOL  = 9'b000100000,
    S_SUM    = 9'b001000000,
    S_WAIT   = 9'b010000000,
    S_DECIDE = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_FW   = 2'd1,
    PH_SUM  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    M_FLOOR = 2'd0,
    M_DAY0  = 2'd1,
    M_BIT   = 2'd2
  } mode_t;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BUDGET     = 2'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

endpackage

// ===== src/min_days_apsp_budget_search.sv =====
// top level: matrix memories, shortest-path sweeps and the day search sequencer
// depends on mdab_pkg and mdab_div
//
//  channel | ports                                         | handshake
//  request | start, busy, in_func/row/col/start_weight/... | start & !busy
//  result  | out_valid, out_feasible, out_days             | one-cycle strobe
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data     | valid & ready
//
// a load request does not raise busy, so loads stream back to back.
// a run request evaluates the floors graph, then day 0, then one graph per search
// bit, and ends early if the floors graph exceeds the budget or day 0 fits; each
// day evaluation after the floors graph starts with a divide, then fills the
// distance memory, runs the shortest-path relaxation on the dual-read distance
// memory and sums the matrix; the result strobes as busy falls.
// reset is synchronous; matrices are not cleared. the receiver cannot stall.
module min_days_apsp_budget_search #(
  parameter int MAX_NODES   = 128,
  parameter int WEIGHT_BITS = 20,
  parameter int SEARCH_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_func,
  input  logic [6:0]             in_row,
  input  logic [6:0]             in_col,
  input  logic [WEIGHT_BITS-1:0] in_start_weight,
  input  logic [WEIGHT_BITS-1:0] in_floor_weight,
  output logic                   out_valid,
  output logic                   out_feasible,
  output logic [31:0]            out_days,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [39:0]            cfg_data
);
  import mdab_pkg::*;

  localparam int IDXW  = $clog2(MAX_NODES);
  localparam int NW    = IDXW + 1;
  localparam int AW    = 2 * IDXW;
  localparam int DEPTH = 1 << AW;
  localparam int WB    = WEIGHT_BITS;
  localparam int DW    = SEARCH_BITS + 1;
  localparam int BW    = (SEARCH_BITS > 1) ? $clog2(SEARCH_BITS) : 1;
  localparam int CW    = ((DW > WB) ? DW : WB) + 3;
  localparam int SUMW  = AW + WB;
  localparam int CMPW  = (SUMW > 40) ? SUMW : 40;

  // memories
  logic [WB-1:0] start_mem [DEPTH];
  logic [WB-1:0] floor_mem [DEPTH];
  logic [WB-1:0] dist_mem  [DEPTH];

  state_t state_r, state_nxt, wait_next_r, wait_next_nxt;
  mode_t  mode_r, mode_nxt;

  logic [7:0]      node_count_r;
  logic [39:0]     budget_r;
  logic [NW-1:0]   n_r, n_nxt;
  logic [IDXW-1:0] nm1;
  logic [IDXW-1:0] cr_r, cr_nxt, cc_r, cc_nxt, ck_r, ck_nxt;
  logic            p_vld_r, p_vld_nxt;
  phase_t          p_ph_r, p_ph_nxt;
  logic [IDXW-1:0] p_row_r, p_row_nxt, p_col_r, p_col_nxt;
  logic            first_r, first_nxt;
  logic [WB-1:0]   dik_r;
  logic [SUMW-1:0] acc_r, acc_nxt;
  logic [DW-1:0]   cand_r, cand_nxt;
  logic [SEARCH_BITS-1:0] l_r, l_nxt;
  logic [BW-1:0]   bit_r, bit_nxt;
  logic [DW-1:0]   u_r;
  logic [NW-1:0]   v_r;
  logic            div_go;
  logic            div_done;
  logic [DW-1:0]   div_quo;
  logic [NW-1:0]   div_rem;
  logic            ov_r, ov_nxt, of_r, of_nxt;
  logic [31:0]     od_r, od_nxt;

  logic [AW-1:0]   addr_a, addr_b, addr_sf, waddr;
  logic [WB-1:0]   rd_a, rd_b, rd_s, rd_f, wdata;
  logic            we;
  logic [IDXW-1:0] lo_idx, hi_idx;
  logic [8:0]      row9, col9, nc9, neff9;
  logic            load_ok;
  logic [CW-1:0]   red, fsum;
  logic [WB-1:0]   w_init;
  logic [WB:0]     t_fw;
  logic            fit;
  logic [63:0]     days64;
  logic [SEARCH_BITS-1:0] l_upd;

  assign nm1 = IDXW'(n_r - NW'(1));

  // load path
  assign row9    = {2'b00, in_row};
  assign col9    = {2'b00, in_col};
  assign load_ok = (row9 < 9'(MAX_NODES)) && (col9 < 9'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (start && !busy && in_func == FUNC_LOAD && load_ok) begin
      start_mem[{row9[IDXW-1:0], col9[IDXW-1:0]}] <= in_start_weight;
      floor_mem[{row9[IDXW-1:0], col9[IDXW-1:0]}] <= in_floor_weight;
    end
    rd_s <= start_mem[addr_sf];
    rd_f <= floor_mem[addr_sf];
  end

  // upper triangle only
  assign lo_idx  = (cr_r < cc_r) ? cr_r : cc_r;
  assign hi_idx  = (cr_r < cc_r) ? cc_r : cr_r;
  assign addr_sf = {lo_idx, hi_idx};

  always_comb begin
    addr_a = {cr_r, cc_r};
    if (state_r == S_FWROW) begin
      addr_a = {cr_r, ck_r};
    end
  end
  assign addr_b = {ck_r, cc_r};

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdata;
    end
    rd_a <= dist_mem[addr_a];
    rd_b <= dist_mem[addr_b];
  end

  // data cycle: weight of the day, relaxation
  always_comb begin
    red = CW'({u_r, 1'b0})
        + CW'({1'b0, p_row_r} < v_r)
        + CW'({1'b0, p_col_r} < v_r);
    fsum = CW'(rd_f) + red;
    if (mode_r == M_FLOOR) begin
      w_init = rd_f;
    end else if (CW'(rd_s) > fsum) begin
      w_init = WB'(CW'(rd_s) - red);
    end else begin
      w_init = rd_f;
    end
    if (p_row_r == p_col_r) begin
      w_init = '0;
    end
    t_fw  = {1'b0, dik_r} + {1'b0, rd_b};
    we    = 1'b0;
    waddr = {p_row_r, p_col_r};
    wdata = w_init;
    if (p_vld_r && p_ph_r == PH_INIT) begin
      we = 1'b1;
    end else if (p_vld_r && p_ph_r == PH_FW && t_fw < {1'b0, rd_a}) begin
      we    = 1'b1;
      wdata = t_fw[WB-1:0];
    end
  end

  mdab_div #(.DW(DW), .NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (cand_r),
    .divisor  (n_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      u_r <= div_quo;
      v_r <= div_rem;
    end
    if (state_r == S_FWCOL && first_r) begin
      dik_r <= rd_a;
    end
  end

  assign nc9   = {1'b0, node_count_r};
  assign neff9 = (nc9 == 9'd0) ? 9'd1 : ((nc9 > 9'(MAX_NODES)) ? 9'(MAX_NODES) : nc9);
  assign fit   = CMPW'(acc_r) <= CMPW'(budget_r);
  assign l_upd = fit ? l_r : cand_r[SEARCH_BITS-1:0];
  assign days64 = 64'(l_upd) + 64'd1;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wait_next_nxt = wait_next_r;
    mode_nxt      = mode_r;
    n_nxt         = n_r;
    cr_nxt        = cr_r;
    cc_nxt        = cc_r;
    ck_nxt        = ck_r;
    p_vld_nxt     = 1'b0;
    p_ph_nxt      = p_ph_r;
    p_row_nxt     = cr_r;
    p_col_nxt     = cc_r;
    first_nxt     = first_r;
    acc_nxt       = acc_r;
    cand_nxt      = cand_r;
    l_nxt         = l_r;
    bit_nxt       = bit_r;
    div_go        = 1'b0;
    ov_nxt        = 1'b0;
    of_nxt        = of_r;
    od_nxt        = od_r;
    if (p_vld_r && p_ph_r == PH_SUM) begin
      acc_nxt = acc_r + SUMW'(rd_a);
    end
    unique case (state_r)
      S_IDLE: begin
        if (start && in_func == FUNC_RUN) begin
          n_nxt     = neff9[NW-1:0];
          mode_nxt  = M_FLOOR;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        acc_nxt = '0;
        cr_nxt  = '0;
        cc_nxt  = '0;
        ck_nxt  = '0;
        if (mode_r == M_FLOOR) begin
          state_nxt = S_INIT;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        p_vld_nxt = 1'b1;
        p_ph_nxt  = PH_INIT;
        if (cc_r == nm1) begin
          cc_nxt = '0;
          if (cr_r == nm1) begin
            cr_nxt        = '0;
            state_nxt     = S_WAIT;
            wait_next_nxt = S_FWROW;
          end else begin
            cr_nxt = cr_r + IDXW'(1);
          end
        end else begin
          cc_nxt = cc_r + IDXW'(1);
        end
      end
      S_FWROW: begin
        cc_nxt    = '0;
        first_nxt = 1'b1;
        state_nxt = S_FWCOL;
      end
      S_FWCOL: begin
        first_nxt = 1'b0;
        p_vld_nxt = 1'b1;
        p_ph_nxt  = PH_FW;
        if (cc_r == nm1) begin
          cc_nxt = '0;
          state_nxt = S_FWROW;
          if (cr_r == nm1) begin
            cr_nxt = '0;
            if (ck_r == nm1) begin
              ck_nxt        = '0;
              state_nxt     = S_WAIT;
              wait_next_nxt = S_SUM;
            end else begin
              ck_nxt = ck_r + IDXW'(1);
            end
          end else begin
            cr_nxt = cr_r + IDXW'(1);
          end
        end else begin
          cc_nxt = cc_r + IDXW'(1);
        end
      end
      S_SUM: begin
        p_vld_nxt = 1'b1;
        p_ph_nxt  = PH_SUM;
        if (cc_r == nm1) begin
          cc_nxt = '0;
          if (cr_r == nm1) begin
            cr_nxt        = '0;
            state_nxt     = S_WAIT;
            wait_next_nxt = S_DECIDE;
          end else begin
            cr_nxt = cr_r + IDXW'(1);
          end
        end else begin
          cc_nxt = cc_r + IDXW'(1);
        end
      end
      S_WAIT: begin
        state_nxt = wait_next_r;
      end
      S_DECIDE: begin
        case (mode_r)
          M_FLOOR: begin
            if (!fit) begin
              ov_nxt    = 1'b1;
              of_nxt    = 1'b0;
              od_nxt    = '0;
              state_nxt = S_IDLE;
            end else begin
              mode_nxt  = M_DAY0;
              cand_nxt  = '0;
              state_nxt = S_PREP;
            end
          end
          M_DAY0: begin
            if (fit) begin
              ov_nxt    = 1'b1;
              of_nxt    = 1'b1;
              od_nxt    = '0;
              state_nxt = S_IDLE;
            end else begin
              mode_nxt  = M_BIT;
              l_nxt     = '0;
              bit_nxt   = BW'(SEARCH_BITS - 1);
              cand_nxt  = DW'(1) << (SEARCH_BITS - 1);
              state_nxt = S_PREP;
            end
          end
          default: begin
            l_nxt = l_upd;
            if (bit_r == '0) begin
              ov_nxt    = 1'b1;
              of_nxt    = 1'b1;
              od_nxt    = days64[31:0];
              state_nxt = S_IDLE;
            end else begin
              bit_nxt   = bit_r - BW'(1);
              cand_nxt  = DW'(l_upd) + (DW'(1) << (bit_r - BW'(1)));
              state_nxt = S_PREP;
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_next_r  <= S_IDLE;
      mode_r       <= M_FLOOR;
      p_vld_r      <= 1'b0;
      ov_r         <= 1'b0;
      node_count_r <= 8'd1;
      budget_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      wait_next_r <= wait_next_nxt;
      mode_r      <= mode_nxt;
      p_vld_r     <= p_vld_nxt;
      ov_r        <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count_r <= cfg_data[7:0];
          CFG_BUDGET:     budget_r     <= cfg_data;
          default: ;
        endcase
      end
    end
    n_r     <= n_nxt;
    cr_r    <= cr_nxt;
    cc_r    <= cc_nxt;
    ck_r    <= ck_nxt;
    p_ph_r  <= p_ph_nxt;
    p_row_r <= p_row_nxt;
    p_col_r <= p_col_nxt;
    first_r <= first_nxt;
    acc_r   <= acc_nxt;
    cand_r  <= cand_nxt;
    l_r     <= l_nxt;
    bit_r   <= bit_nxt;
    of_r    <= of_nxt;
    od_r    <= od_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = ov_r;
  assign out_feasible = of_r;
  assign out_days     = od_r;

endmodule

// ===== src/mdab_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// standalone, no package dependencies
module mdab_div #(
  parameter int DW = 32,
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quo,
  output logic [NW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW:0]   trial;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(DW);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = NW'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[NW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== src/mdab_checker.sv =====
// port-level checks on the search block's request and result timing
// depends on mdab_pkg; bound to min_days_apsp_budget_search
module mdab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_feasible,
  input logic [31:0] out_days
);
  import mdab_pkg::*;

  // a run request always occupies the block
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_RUN |=> busy)
    else $error("run request did not raise busy");

  // the result appears exactly as the run finishes
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("run finished without a result");

  a_result_fell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $fell(busy))
    else $error("result outside the end of a run");

  a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_feasible |-> out_days == 32'd0)
    else $error("infeasible result carries nonzero days");

endmodule

bind min_days_apsp_budget_search mdab_checker u_mdab_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_func      (in_func),
  .out_valid    (out_valid),
  .out_feasible (out_feasible),
  .out_days     (out_days)
);
